/* rtl/crsf_frame_receiver_macros.svh */
// assertion macros shared by the crsf receiver rtl
// no dependencies; included inside module bodies
`ifndef CRSF_FRAME_RECEIVER_MACROS_SVH
`define CRSF_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CRSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("crsf receiver check failed");

// next-cycle implication, disabled while reset is asserted
`define CRSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("crsf receiver check failed");

`endif

/* rtl/crsf_pkg.sv */
// types, codes and crc helper for the crsf frame receiver
// no dependencies
package crsf_pkg;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY
    } t_phase;

    localparam logic [7:0] CFG_SYNC_ADDR = 8'd0;
    localparam logic [7:0] CFG_RC_TYPE   = 8'd1;

    localparam logic [7:0] SYNC_ADDR_RESET = 8'hC8;
    localparam logic [7:0] RC_TYPE_RESET   = 8'h16;
    localparam logic [7:0] CRC_POLY        = 8'hD5;

    typedef struct packed {
        logic        frame_good;
        logic        crc_mismatch;
        logic [7:0]  frame_kind;
        logic        rc_frame;
        logic [31:0] bytes_seen;
        logic [31:0] good_frames;
        logic [31:0] rc_frames;
        logic [7:0]  last_good_kind;
    } t_result;

    // crc-8 dvb-s2, msb first, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/crsf_if.sv */
// channel interfaces of the crsf frame receiver: byte in, result out, config write
// depends on nothing
interface crsf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crsf_result_if;
    logic        valid;
    logic        ready;
    logic        frame_good;
    logic        crc_mismatch;
    logic [7:0]  frame_kind;
    logic        rc_frame;
    logic [31:0] bytes_seen;
    logic [31:0] good_frames;
    logic [31:0] rc_frames;
    logic [7:0]  last_good_kind;
    modport source (output valid, output frame_good, output crc_mismatch, output frame_kind,
                    output rc_frame, output bytes_seen, output good_frames, output rc_frames,
                    output last_good_kind, input ready);
    modport sink   (input valid, input frame_good, input crc_mismatch, input frame_kind,
                    input rc_frame, input bytes_seen, input good_frames, input rc_frames,
                    input last_good_kind, output ready);
endinterface

interface crsf_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/crsf_frame_receiver.sv */
// crsf frame receiver top level: parser, crc-8 check and statistics counters
// depends on crsf_pkg, crsf_if.sv and crsf_frame_receiver_macros.svh
//
// usage:
//   i_rx takes one raw serial byte per transaction. every accepted byte produces
//   exactly one transaction on o_res with frame flags, the frame type and the
//   running byte / good frame / rc frame counters (all wrap at 32 bits).
//   i_cfg writes index 0 (sync address) or index 1 (rc frame type); other
//   indexes are ignored. it is always ready; write only while the block is idle.
//   latency: the result for a byte is valid the cycle after the byte is taken.
//   throughput: one byte per cycle unless stalled; parsing, crc update and
//   counters are done in one pass between byte handshake and result register.
//   stall: i_rx.ready drops only while a result sits unclaimed in the output
//   register and o_res.ready is low; a result is never dropped or repeated.
//   reset (i_rst_n low, synchronous): parser back to hunting, counters and
//   last type to zero, registers to 0xC8 and 0x16, output register empty.
module crsf_frame_receiver #(
    parameter int MAX_BODY = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    crsf_byte_if.sink            i_rx,
    crsf_result_if.source        o_res,
    crsf_cfg_if.sink             i_cfg
);
    import crsf_pkg::*;
    `include "crsf_frame_receiver_macros.svh"

    localparam int LW = $clog2(MAX_BODY + 1);

    t_phase      r_phase, n_phase;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_idx, n_idx;
    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_crc, n_crc;
    logic [31:0] r_bytes, n_bytes;
    logic [31:0] r_good, n_good;
    logic [31:0] r_rc, n_rc;
    logic [7:0]  r_recent, n_recent;
    logic [7:0]  r_sync_addr;
    logic [7:0]  r_rc_type;
    logic        r_out_valid;
    t_result     r_out, n_out;

    logic rx_fire;
    logic [LW-1:0] idx_inc;
    logic [7:0] kind_now;

    assign i_rx.ready  = !r_out_valid || o_res.ready;
    assign rx_fire     = i_rx.valid && i_rx.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_addr <= SYNC_ADDR_RESET;
            r_rc_type   <= RC_TYPE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SYNC_ADDR: r_sync_addr <= i_cfg.data;
                CFG_RC_TYPE:   r_rc_type   <= i_cfg.data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
        end else if (rx_fire) begin
            r_phase <= n_phase;
        end
    end

    assign idx_inc  = r_idx + 1'b1;
    assign kind_now = (r_idx == '0) ? i_rx.rx_byte : r_kind;

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_idx    = r_idx;
        n_kind   = r_kind;
        n_crc    = r_crc;
        n_bytes  = r_bytes + 32'd1;
        n_good   = r_good;
        n_rc     = r_rc;
        n_recent = r_recent;
        n_out    = '0;
        case (r_phase)
            PH_HUNT: begin
                if (i_rx.rx_byte == r_sync_addr) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (i_rx.rx_byte < 8'd2 || i_rx.rx_byte > 8'(MAX_BODY)) begin
                    n_phase = PH_HUNT;
                end else begin
                    n_len   = LW'(i_rx.rx_byte);
                    n_idx   = '0;
                    n_crc   = '0;
                    n_kind  = '0;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_kind = kind_now;
                n_idx  = idx_inc;
                if (idx_inc >= r_len) begin
                    // last body byte carries the crc
                    n_phase = PH_HUNT;
                    if (r_crc == i_rx.rx_byte) begin
                        n_out.frame_good = 1'b1;
                        n_out.frame_kind = kind_now;
                        n_good           = r_good + 32'd1;
                        n_recent         = kind_now;
                        if (kind_now == r_rc_type) begin
                            n_out.rc_frame = 1'b1;
                            n_rc           = r_rc + 32'd1;
                        end
                    end else begin
                        n_out.crc_mismatch = 1'b1;
                    end
                end else begin
                    n_crc = crc8_step(r_crc, i_rx.rx_byte);
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
        n_out.bytes_seen     = n_bytes;
        n_out.good_frames    = n_good;
        n_out.rc_frames      = n_rc;
        n_out.last_good_kind = n_recent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_idx       <= '0;
            r_kind      <= '0;
            r_crc       <= '0;
            r_bytes     <= '0;
            r_good      <= '0;
            r_rc        <= '0;
            r_recent    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (rx_fire) begin
                r_len    <= n_len;
                r_idx    <= n_idx;
                r_kind   <= n_kind;
                r_crc    <= n_crc;
                r_bytes  <= n_bytes;
                r_good   <= n_good;
                r_rc     <= n_rc;
                r_recent <= n_recent;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_fire) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.frame_good     = r_out.frame_good;
    assign o_res.crc_mismatch   = r_out.crc_mismatch;
    assign o_res.frame_kind     = r_out.frame_kind;
    assign o_res.rc_frame       = r_out.rc_frame;
    assign o_res.bytes_seen     = r_out.bytes_seen;
    assign o_res.good_frames    = r_out.good_frames;
    assign o_res.rc_frames      = r_out.rc_frames;
    assign o_res.last_good_kind = r_out.last_good_kind;

    `CRSF_ASSERT_IMPL(a_flags_exclusive, i_clk, i_rst_n, r_out_valid,
        !(r_out.frame_good && r_out.crc_mismatch))
    `CRSF_ASSERT_IMPL(a_rc_needs_good, i_clk, i_rst_n, r_out_valid && r_out.rc_frame,
        r_out.frame_good)
    `CRSF_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, rx_fire,
        r_out_valid && r_out.bytes_seen == r_bytes)
    `CRSF_ASSERT_IMPL(a_body_len_valid, i_clk, i_rst_n, r_phase == PH_BODY,
        r_len >= LW'(2) && r_idx < r_len)
    `CRSF_ASSERT_IMPL(a_counters_follow, i_clk, i_rst_n, r_out_valid,
        r_out.rc_frames == r_rc && r_out.good_frames == r_good)

endmodule

/* dv/tb_top.sv */
// self-checking bench for crsf_frame_receiver: framed byte traffic, crc and counter checks
// depends on crsf_pkg, the channel interfaces in crsf_if.sv and the receiver rtl
`timescale 1ns / 100ps

module tb_top;
    import crsf_pkg::*;

    localparam int         HALF_PERIOD    = 6;
    localparam int         RESET_CYCLES   = 11;
    localparam int         MAX_BODY       = 64;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         DRAIN_CYCLES   = 20;
    localparam logic [7:0] CFG_IDX_TOP    = 8'hFF;

    logic i_clk;
    logic i_rst_n;

    crsf_byte_if   rx_if ();
    crsf_result_if res_if ();
    crsf_cfg_if    cfg_if ();

    crsf_frame_receiver #(.MAX_BODY(MAX_BODY)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // bytes waiting to go out on the link, and results owed by the receiver
    logic [7:0] link_bytes[$];
    t_result    result_due[$];

    // register copies
    logic [7:0] cfg_sync;
    logic [7:0] cfg_rc_type;

    // parser copy
    t_phase      prs_phase;
    logic [6:0]  prs_len;
    logic [6:0]  prs_idx;
    logic [7:0]  prs_kind;
    logic [7:0]  prs_crc;
    logic [31:0] byte_cnt;
    logic [31:0] good_cnt;
    logic [31:0] rc_cnt;
    logic [7:0]  recent_kind;

    int crc_err_cnt;
    int settings_seen;
    int failures;
    int idle_cycles;

    // sender burst shaping
    int burst_left;
    int gap_left;

    // receiver stall pattern
    logic [7:0] stall_tick;
    int         stall_mode;

    // crc-8, polynomial 0xd5, msb first
    function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            if (acc[7] ^ data[i]) begin
                acc = (acc << 1) ^ 8'hD5;
            end else begin
                acc = acc << 1;
            end
        end
        return acc;
    endfunction

    // advance the parser copy by one byte and return the result it owes
    function automatic t_result parse_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        byte_cnt = byte_cnt + 32'd1;
        case (prs_phase)
            PH_HUNT: begin
                if (b == cfg_sync) prs_phase = PH_LEN;
            end
            PH_LEN: begin
                if (b < 8'd2 || b > 8'(MAX_BODY)) begin
                    prs_phase = PH_HUNT;
                end else begin
                    prs_len   = b[6:0];
                    prs_idx   = '0;
                    prs_crc   = '0;
                    prs_kind  = '0;
                    prs_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (prs_idx == 7'd0) prs_kind = b;
                prs_idx = prs_idx + 7'd1;
                if (prs_idx >= prs_len) begin
                    prs_phase = PH_HUNT;
                    if (prs_crc == b) begin
                        r.frame_good = 1'b1;
                        r.frame_kind = prs_kind;
                        good_cnt     = good_cnt + 32'd1;
                        recent_kind  = prs_kind;
                        if (prs_kind == cfg_rc_type) begin
                            r.rc_frame = 1'b1;
                            rc_cnt     = rc_cnt + 32'd1;
                        end
                    end else begin
                        r.crc_mismatch = 1'b1;
                        crc_err_cnt++;
                    end
                end else begin
                    prs_crc = crc_next(prs_crc, b);
                end
            end
            default: prs_phase = PH_HUNT;
        endcase
        r.bytes_seen     = byte_cnt;
        r.good_frames    = good_cnt;
        r.rc_frames      = rc_cnt;
        r.last_good_kind = recent_kind;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
        end
    endfunction

    // byte driver: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= '0;
        end else begin
            if (rx_if.valid && rx_if.ready) result_due.push_back(parse_byte(rx_if.rx_byte));
            if (!rx_if.valid || rx_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    rx_if.valid <= 1'b0;
                end else if (link_bytes.size() > 0) begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= link_bytes.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        if ($urandom_range(0, 5) == 0) begin
                            burst_left = $urandom_range(100, 300);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 40);
                            gap_left   = $urandom_range(0, 8);
                        end
                    end
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (result_due.size() == 0) begin
                    failures++;
                    $display("%0t: result transaction with none expected, bytes_seen 0x%0h",
                             $time, res_if.bytes_seen);
                end else begin
                    want = result_due.pop_front();
                    check_field("frame_good", 32'(want.frame_good), 32'(res_if.frame_good));
                    check_field("crc_mismatch", 32'(want.crc_mismatch),
                                32'(res_if.crc_mismatch));
                    check_field("frame_kind", 32'(want.frame_kind), 32'(res_if.frame_kind));
                    check_field("rc_frame", 32'(want.rc_frame), 32'(res_if.rc_frame));
                    check_field("bytes_seen", want.bytes_seen, res_if.bytes_seen);
                    check_field("good_frames", want.good_frames, res_if.good_frames);
                    check_field("rc_frames", want.rc_frames, res_if.rc_frames);
                    check_field("last_good_kind", 32'(want.last_good_kind),
                                32'(res_if.last_good_kind));
                end
            end
            stall_tick <= stall_tick + 8'd1;
            if (stall_tick == 8'd0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= ($urandom_range(0, 3) != 0);
                2:       res_if.ready <= ($urandom_range(0, 3) == 0);
                default: res_if.ready <= (stall_tick[2:0] < 3'd5);
            endcase
        end
    end

    // no transaction on any channel for too long means the receiver hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results still due", $time, result_due.size());
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_SYNC_ADDR) begin
            cfg_sync = val;
        end else if (idx == CFG_RC_TYPE) begin
            cfg_rc_type = val;
        end
        settings_seen++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (link_bytes.size() != 0 || rx_if.valid
                                    || result_due.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // address, length, type, payload, crc; keep limits how many body bytes go out
    task automatic queue_frame(input logic [7:0] len, input logic [7:0] kind,
                               input bit corrupt, input int keep);
        logic [7:0] body[$];
        logic [7:0] crc;
        logic [7:0] b;
        body.push_back(kind);
        crc = crc_next(8'h00, kind);
        for (int i = 2; i < len; i++) begin
            b = 8'($urandom);
            body.push_back(b);
            crc = crc_next(crc, b);
        end
        if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
        body.push_back(crc);
        link_bytes.push_back(cfg_sync);
        link_bytes.push_back(len);
        for (int i = 0; i < keep && i < body.size(); i++) link_bytes.push_back(body[i]);
    endtask

    task automatic queue_traffic(input int n);
        int         target;
        int         pick;
        logic [7:0] len;
        logic [7:0] kind;
        target = link_bytes.size() + n;
        while (link_bytes.size() < target) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0:       len = 8'(MAX_BODY);
                1:       len = 8'($urandom_range(13, MAX_BODY - 1));
                default: len = 8'($urandom_range(2, 12));
            endcase
            if ($urandom_range(0, 3) == 0) begin
                kind = cfg_rc_type;
            end else if ($urandom_range(0, 7) == 0) begin
                kind = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end else begin
                kind = 8'($urandom);
            end
            if (pick < 70) begin
                queue_frame(len, kind, $urandom_range(0, 3) == 0, MAX_BODY);
            end else if (pick < 80) begin
                // out of range length, consumed and never taken as an address
                link_bytes.push_back(cfg_sync);
                if ($urandom_range(0, 3) == 0) begin
                    link_bytes.push_back(8'($urandom_range(0, 1)));
                end else begin
                    link_bytes.push_back(8'($urandom_range(MAX_BODY + 1, 255)));
                end
            end else if (pick < 90) begin
                // cut short: whatever follows is read as body
                queue_frame(len, kind, 1'b0, $urandom_range(0, len - 1));
            end else begin
                repeat ($urandom_range(1, 5)) link_bytes.push_back(8'($urandom));
            end
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        cfg_sync      = SYNC_ADDR_RESET;
        cfg_rc_type   = RC_TYPE_RESET;
        prs_phase     = PH_HUNT;
        prs_len       = '0;
        prs_idx       = '0;
        prs_kind      = '0;
        prs_crc       = '0;
        byte_cnt      = '0;
        good_cnt      = '0;
        rc_cnt        = '0;
        recent_kind   = '0;
        crc_err_cnt   = 0;
        settings_seen = 1;
        failures      = 0;
        idle_cycles   = 0;
        burst_left    = 1;
        gap_left      = 0;
        stall_tick    = '0;
        stall_mode    = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: line noise, short and long lengths, length byte equal to the
        // address, minimum rc frame with good and bad crc
        link_bytes.push_back(8'h00);
        link_bytes.push_back(8'hFF);
        link_bytes.push_back(cfg_sync);
        link_bytes.push_back(8'd0);
        link_bytes.push_back(cfg_sync);
        link_bytes.push_back(8'd1);
        link_bytes.push_back(cfg_sync);
        link_bytes.push_back(8'(MAX_BODY + 1));
        link_bytes.push_back(cfg_sync);
        link_bytes.push_back(cfg_sync);
        queue_frame(8'd2, cfg_rc_type, 1'b0, MAX_BODY);
        queue_frame(8'd2, cfg_rc_type, 1'b1, MAX_BODY);
        queue_frame(8'd3, 8'hFF, 1'b0, MAX_BODY);
        wait_drained();

        queue_traffic(400);
        wait_drained();
        write_reg(CFG_IDX_TOP, 8'($urandom));
        write_reg(CFG_SYNC_ADDR, 8'h00);
        write_reg(CFG_RC_TYPE, 8'hFF);
        queue_traffic(380);
        wait_drained();
        write_reg(CFG_SYNC_ADDR, 8'hFF);
        write_reg(CFG_RC_TYPE, 8'h00);
        queue_traffic(380);
        wait_drained();
        write_reg(8'($urandom_range(2, 254)), 8'($urandom));
        write_reg(CFG_SYNC_ADDR, 8'($urandom));
        write_reg(CFG_RC_TYPE, 8'($urandom));
        queue_traffic(380);
        wait_drained();
        write_reg(CFG_SYNC_ADDR, SYNC_ADDR_RESET);
        write_reg(CFG_RC_TYPE, RC_TYPE_RESET);
        queue_traffic(380);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (result_due.size() != 0) begin
            failures++;
            $display("%0t: %0d results never arrived", $time, result_due.size());
        end
        $display("covered %0d bytes: %0d good frames (%0d rc), %0d crc errors",
                 byte_cnt, good_cnt, rc_cnt, crc_err_cnt);
        $display("register writes: %0d, mismatches: %0d", settings_seen - 1, failures);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/crsf_pkg.sv
rtl/crsf_if.sv
rtl/crsf_frame_receiver.sv
dv/tb_top.sv
